// ===== hw/rtl/pftls_pkg.sv =====
// Package: shared constants and types for the fault latency stats block.
`default_nettype none
package pftls_pkg;
   localparam int ID_W = 23;
   localparam int KEY_W = 46;
   localparam int TS_W = 64;
   localparam int DEF_START_SLOTS = 64;
   localparam int DEF_STAT_SLOTS = 64;
   localparam logic [31:0] MAJOR_BIT = 32'h0000_0004;

   localparam logic [2:0] OP_ENTRY  = 3'd0;
   localparam logic [2:0] OP_EXIT   = 3'd1;
   localparam logic [2:0] OP_DETAIL = 3'd2;
   localparam logic [2:0] OP_RESET  = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   localparam logic [1:0] KIND_MAJOR    = 2'd0;
   localparam logic [1:0] KIND_DETAIL   = 2'd1;
   localparam logic [1:0] KIND_STATS    = 2'd2;
   localparam logic [1:0] KIND_NOTFOUND = 2'd3;

   localparam logic CSR_TARGET_PID = 1'b0;
   localparam logic CSR_DETAIL_EN  = 1'b1;

   // search token passed along a cell chain
   typedef struct packed {
      logic       hit;
      logic       free;
      logic [11:0] hit_idx;
      logic [11:0] free_idx;
   } scan_type;

   typedef struct packed {
      logic [TS_W-1:0] first_seen;
      logic [TS_W-1:0] total;
      logic [TS_W-1:0] major;
      logic [TS_W-1:0] minor;
      logic [TS_W-1:0] max;
      logic [TS_W-1:0] min;
   } stat_rec_type;
endpackage
`default_nettype wire

// ===== hw/rtl/pftls_start_cell.sv =====
// Start table cell: one start slot, key match and chain token.
`default_nettype none
module pftls_start_cell #(
   parameter int IDX = 0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [pftls_pkg::KEY_W-1:0] key,
   input  wire pftls_pkg::scan_type        scan_i,
   output pftls_pkg::scan_type             scan_o,
   input  wire logic                       wr_en,
   input  wire logic [11:0]                wr_idx,
   input  wire logic                       wr_valid,
   input  wire logic [pftls_pkg::TS_W-1:0] wr_time,
   input  wire logic [11:0]                rd_idx,
   output logic [pftls_pkg::TS_W-1:0]      rd_time
);
   logic                       valid_ff;
   logic [pftls_pkg::KEY_W-1:0] key_ff;
   logic [pftls_pkg::TS_W-1:0] time_ff;
   logic                       sel;

   assign sel = wr_en && (wr_idx == 12'(IDX));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sel) begin
         valid_ff <= wr_valid;
      end
      if (sel && wr_valid) begin
         key_ff  <= key;
         time_ff <= wr_time;
      end
   end

   always_comb begin
      scan_o = scan_i;
      if (!scan_i.hit && valid_ff && key_ff == key) begin
         scan_o.hit = 1'b1;
         scan_o.hit_idx = 12'(IDX);
      end
      if (!scan_i.free && !valid_ff) begin
         scan_o.free = 1'b1;
         scan_o.free_idx = 12'(IDX);
      end
   end

   assign rd_time = (rd_idx == 12'(IDX)) ? time_ff : '0;
endmodule
`default_nettype wire

// ===== hw/rtl/pftls_stat_cell.sv =====
// Stats table cell: one statistics slot, key match and chain token.
`default_nettype none
module pftls_stat_cell #(
   parameter int IDX = 0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [pftls_pkg::KEY_W-1:0] key,
   input  wire pftls_pkg::scan_type        scan_i,
   output pftls_pkg::scan_type             scan_o,
   input  wire logic                       wr_en,
   input  wire logic [11:0]                wr_idx,
   input  wire logic                       wr_valid,
   input  wire pftls_pkg::stat_rec_type    wr_rec,
   input  wire logic [11:0]                rd_idx,
   output pftls_pkg::stat_rec_type         rd_rec
);
   logic                       valid_ff;
   logic [pftls_pkg::KEY_W-1:0] key_ff;
   pftls_pkg::stat_rec_type    rec_ff;
   logic                       sel;

   assign sel = wr_en && (wr_idx == 12'(IDX));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sel) begin
         valid_ff <= wr_valid;
      end
      if (sel && wr_valid) begin
         key_ff <= key;
         rec_ff <= wr_rec;
      end
   end

   always_comb begin
      scan_o = scan_i;
      if (!scan_i.hit && valid_ff && key_ff == key) begin
         scan_o.hit = 1'b1;
         scan_o.hit_idx = 12'(IDX);
      end
      if (!scan_i.free && !valid_ff) begin
         scan_o.free = 1'b1;
         scan_o.free_idx = 12'(IDX);
      end
   end

   assign rd_rec = (rd_idx == 12'(IDX)) ? rec_ff : '0;
endmodule
`default_nettype wire

// ===== hw/rtl/per_thread_fault_latency_stats_core.sv =====
// Top level: per-thread fault latency statistics over two chains of cells.
// Steps per request: lookup, data read, update, then the registered response.
// A new start is taken only while idle; busy is high in the lookup, read and update states.
// The slot chains are scanned combinationally in the lookup cycle.
// Reset: synchronous, clears all valid bits and config; no clearing pass.
// The receiver cannot stall; each result stands for one cycle.
`default_nettype none
module per_thread_fault_latency_stats_core #(
   parameter int START_SLOTS = pftls_pkg::DEF_START_SLOTS,
   parameter int STAT_SLOTS  = pftls_pkg::DEF_STAT_SLOTS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_op,
   input  wire logic [22:0] req_pid,
   input  wire logic [22:0] req_tid,
   input  wire logic [63:0] req_timestamp,
   input  wire logic [31:0] req_ret_flags,
   input  wire logic [63:0] req_fault_address,
   input  wire logic [31:0] req_error_code,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [22:0] csr_data,
   output logic             rsp_valid,
   output logic [1:0]       rsp_kind,
   output logic [22:0]      rsp_out_pid,
   output logic [22:0]      rsp_out_tid,
   output logic [63:0]      rsp_duration,
   output logic [63:0]      rsp_out_address,
   output logic [31:0]      rsp_out_flags,
   output logic [63:0]      rsp_total_time,
   output logic [63:0]      rsp_major_count,
   output logic [63:0]      rsp_minor_count,
   output logic [63:0]      rsp_max_time,
   output logic [63:0]      rsp_min_time,
   output logic [63:0]      rsp_first_seen
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_UPD  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [22:0] tpid_ff;
   logic        den_ff;
   logic [2:0]  op_ff;
   logic [22:0] pid_ff, tid_ff;
   logic [63:0] ts_ff, addr_ff;
   logic [31:0] rf_ff, ec_ff;
   pftls_pkg::scan_type ss_ff, ts_scan_ff;
   logic [63:0] stime_ff;
   pftls_pkg::stat_rec_type srec_ff;

   logic [pftls_pkg::KEY_W-1:0] key;
   assign key = {pid_ff, tid_ff};

   pftls_pkg::scan_type sc [START_SLOTS+1];
   pftls_pkg::scan_type tc [STAT_SLOTS+1];
   logic [63:0] st_rd [START_SLOTS];
   pftls_pkg::stat_rec_type sr_rd [STAT_SLOTS];

   logic traced, major;
   logic [63:0] dur;
   logic s_wen, s_wval, t_wen;
   logic [11:0] s_widx, t_widx;
   logic [63:0] s_wtime;
   pftls_pkg::stat_rec_type t_wrec;

   assign sc[0] = '0;
   assign tc[0] = '0;
   assign traced = (tpid_ff == '0) || (pid_ff == tpid_ff);
   assign major = (rf_ff & pftls_pkg::MAJOR_BIT) != '0;
   assign dur = ts_ff - stime_ff;
   assign busy = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;

   genvar g;
   generate
      for (g = 0; g < START_SLOTS; g++) begin : g_start
         pftls_start_cell #(.IDX(g)) u_cell (
            .clock(clock), .reset(reset), .key(key),
            .scan_i(sc[g]), .scan_o(sc[g+1]),
            .wr_en(s_wen), .wr_idx(s_widx), .wr_valid(s_wval), .wr_time(s_wtime),
            .rd_idx(ss_ff.hit_idx), .rd_time(st_rd[g])
         );
      end
      for (g = 0; g < STAT_SLOTS; g++) begin : g_stat
         pftls_stat_cell #(.IDX(g)) u_cell (
            .clock(clock), .reset(reset), .key(key),
            .scan_i(tc[g]), .scan_o(tc[g+1]),
            .wr_en(t_wen), .wr_idx(t_widx), .wr_valid(s_wval), .wr_rec(t_wrec),
            .rd_idx(ts_scan_ff.hit_idx), .rd_rec(sr_rd[g])
         );
      end
   endgenerate

   logic [63:0] st_or;
   pftls_pkg::stat_rec_type sr_or;
   always_comb begin
      st_or = '0;
      sr_or = '0;
      for (int i = 0; i < START_SLOTS; i++) st_or = st_or | st_rd[i];
      for (int i = 0; i < STAT_SLOTS; i++) sr_or = sr_or | sr_rd[i];
   end

   always_comb begin
      s_wen = 1'b0; s_wval = 1'b0; s_widx = ss_ff.hit_idx; s_wtime = ts_ff;
      t_wen = 1'b0; t_widx = ts_scan_ff.hit_idx; t_wrec = srec_ff;
      if (state_ff == ST_UPD) begin
         unique case (op_ff)
            pftls_pkg::OP_ENTRY: begin
               s_wval = 1'b1;
               s_wen = traced && (ss_ff.hit || ss_ff.free);
               s_widx = ss_ff.hit ? ss_ff.hit_idx : ss_ff.free_idx;
            end
            pftls_pkg::OP_EXIT: begin
               s_wen = traced && ss_ff.hit;
               s_wval = 1'b0;
            end
            pftls_pkg::OP_RESET: begin
               s_wen = ss_ff.hit;
               t_wen = ts_scan_ff.hit;
            end
            default: ;
         endcase
      end
      // stats write on exit happens with valid set; handled in a separate cycle below
      if (state_ff == ST_READ && op_ff == pftls_pkg::OP_EXIT && traced && ss_ff.hit) begin
         t_wen = ts_scan_ff.hit || ts_scan_ff.free;
         s_wval = 1'b1;
         if (ts_scan_ff.hit) begin
            t_widx = ts_scan_ff.hit_idx;
            t_wrec = sr_or;
            t_wrec.total = sr_or.total + (ts_ff - st_or);
            if (major) t_wrec.major = sr_or.major + 64'd1;
            else t_wrec.minor = sr_or.minor + 64'd1;
            if ((ts_ff - st_or) > sr_or.max) t_wrec.max = ts_ff - st_or;
            if (sr_or.min == '0 || (ts_ff - st_or) < sr_or.min) t_wrec.min = ts_ff - st_or;
         end else begin
            t_widx = ts_scan_ff.free_idx;
            t_wrec.first_seen = ts_ff;
            t_wrec.total = ts_ff - st_or;
            t_wrec.major = major ? 64'd1 : 64'd0;
            t_wrec.minor = major ? 64'd0 : 64'd1;
            t_wrec.max = ts_ff - st_or;
            t_wrec.min = ts_ff - st_or;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_LOOK;
         ST_LOOK: state_in = ST_READ;
         ST_READ: state_in = ST_UPD;
         ST_UPD:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tpid_ff <= '0;
         den_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            if (csr_index == pftls_pkg::CSR_TARGET_PID) tpid_ff <= csr_data;
            else den_ff <= csr_data[0];
         end
         rsp_valid <= 1'b0;
         if (state_ff == ST_UPD) begin
            unique case (op_ff)
               pftls_pkg::OP_EXIT:   rsp_valid <= traced && ss_ff.hit && major;
               pftls_pkg::OP_DETAIL: rsp_valid <= traced && den_ff;
               pftls_pkg::OP_READ:   rsp_valid <= 1'b1;
               default: ;
            endcase
         end
      end
      if (start && !busy) begin
         op_ff <= req_op; pid_ff <= req_pid; tid_ff <= req_tid;
         ts_ff <= req_timestamp; rf_ff <= req_ret_flags;
         addr_ff <= req_fault_address; ec_ff <= req_error_code;
      end
      if (state_ff == ST_LOOK) begin
         ss_ff <= sc[START_SLOTS];
         ts_scan_ff <= tc[STAT_SLOTS];
      end
      if (state_ff == ST_READ) begin
         stime_ff <= st_or;
         srec_ff <= sr_or;
      end
      if (state_ff == ST_UPD) begin
         rsp_out_pid <= pid_ff;
         rsp_out_tid <= tid_ff;
         rsp_duration <= '0; rsp_out_address <= '0; rsp_out_flags <= '0;
         rsp_total_time <= '0; rsp_major_count <= '0; rsp_minor_count <= '0;
         rsp_max_time <= '0; rsp_min_time <= '0; rsp_first_seen <= '0;
         rsp_kind <= pftls_pkg::KIND_MAJOR;
         if (op_ff == pftls_pkg::OP_EXIT) begin
            rsp_duration <= dur;
         end else if (op_ff == pftls_pkg::OP_DETAIL) begin
            rsp_kind <= pftls_pkg::KIND_DETAIL;
            rsp_out_address <= addr_ff;
            rsp_out_flags <= ec_ff;
         end else if (ts_scan_ff.hit) begin
            rsp_kind <= pftls_pkg::KIND_STATS;
            rsp_total_time <= srec_ff.total; rsp_major_count <= srec_ff.major;
            rsp_minor_count <= srec_ff.minor; rsp_max_time <= srec_ff.max;
            rsp_min_time <= srec_ff.min; rsp_first_seen <= srec_ff.first_seen;
         end else begin
            rsp_kind <= pftls_pkg::KIND_NOTFOUND;
         end
      end
   end

`ifndef ASSERT_OFF
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_UPD) else $error("stray result");
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");
`endif
endmodule
`default_nettype wire
